>>> hdl/sitod_pkg.sv
package sitod_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    // Operation applied to every digit cell in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_BIT,
        CELL_DIGIT
    } t_cell_op;

    localparam logic [6:0] ASCII_ZERO  = 7'd48;
    localparam logic [6:0] ASCII_MINUS = 7'd45;
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

endpackage

>>> hdl/sitod_cell.sv
module sitod_cell (
    input  logic                i_clk,
    input  sitod_pkg::t_cell_op i_op,
    input  logic                i_bit,
    input  logic [3:0]          i_digit,
    output logic                o_bit,
    output logic [3:0]          o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] adj;

    // add-3 correction before the shift
    assign adj     = (r_digit >= sitod_pkg::BCD_ADJ_MIN) ? r_digit + sitod_pkg::BCD_ADJ_ADD
                                                         : r_digit;
    assign o_bit   = adj[3];
    assign o_digit = r_digit;

    always_comb begin
        case (i_op)
            sitod_pkg::CELL_CLEAR: n_digit = 4'd0;
            sitod_pkg::CELL_BIT:   n_digit = {adj[2:0], i_bit};
            sitod_pkg::CELL_DIGIT: n_digit = i_digit;
            default:               n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

>>> hdl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
// Input channel: i_valid / o_stall with i_value, a two's-complement integer.
// Output channel: o_valid / i_stall with o_character (ASCII) and o_last.
// Each item gives a run of 1 to 11 characters (at 32 bits): an optional '-',
// then the digits most significant first without leading zeros; o_last marks
// the final character. Zero gives a single '0'.
// One item at a time: o_stall stays high from acceptance until the last
// character has been loaded into the output register.
// Steps per item: the accept, then bit-serial double dabble through the row
// of BCD digit cells, then the sign if negative, then the digits shift out
// of the row one digit cell at a time, most significant first (leading zero
// cells are dropped as they reach the top).
// A stall on the output holds the output register and pauses the digit
// shifting; nothing is lost. Synchronous active-low reset empties the
// output register and returns to idle; a run in progress is dropped.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [6:0]                    o_character,
    output logic                          o_last
);

    localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int CNT_W      = $clog2(VALUE_WIDTH);

    sitod_pkg::t_state r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic                   r_neg, n_neg;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_seen, n_seen;
    logic                   r_ovalid;
    logic [6:0]             r_char;
    logic                   r_last;

    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag_in;
    sitod_pkg::t_cell_op    cell_op;
    logic [NUM_DIGITS:0]    bit_chain;
    logic [3:0]             dig [NUM_DIGITS];
    logic [3:0]             top_digit;
    logic                   out_free;
    logic                   out_load;
    logic [6:0]             n_char;
    logic                   n_last;
    logic                   final_cell;

    assign raw       = i_value;
    assign mag_in    = raw[VALUE_WIDTH-1] ? (~raw) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1} : raw;
    assign top_digit = dig[NUM_DIGITS-1];
    assign out_free  = !r_ovalid || !i_stall;
    assign final_cell = (r_cnt == CNT_W'(NUM_DIGITS - 1));
    assign bit_chain[0] = r_mag[VALUE_WIDTH-1];

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
            sitod_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (cell_op),
                .i_bit   (bit_chain[g]),
                .i_digit ((g == 0) ? 4'd0 : dig[(g == 0) ? 0 : g - 1]),
                .o_bit   (bit_chain[g+1]),
                .o_digit (dig[g])
            );
        end
    endgenerate

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        n_seen   = r_seen;
        cell_op  = sitod_pkg::CELL_HOLD;
        out_load = 1'b0;
        n_char   = sitod_pkg::ASCII_ZERO + {3'b000, top_digit};
        n_last   = final_cell;
        case (r_state)
            sitod_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_mag   = mag_in;
                    n_neg   = raw[VALUE_WIDTH-1];
                    n_cnt   = '0;
                    n_seen  = 1'b0;
                    cell_op = sitod_pkg::CELL_CLEAR;
                    n_state = sitod_pkg::ST_CONV;
                end
            end
            sitod_pkg::ST_CONV: begin
                cell_op = sitod_pkg::CELL_BIT;
                n_mag   = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_WIDTH - 1)) begin
                    n_cnt   = '0;
                    n_state = r_neg ? sitod_pkg::ST_SIGN : sitod_pkg::ST_DIGITS;
                end
            end
            sitod_pkg::ST_SIGN: begin
                n_char = sitod_pkg::ASCII_MINUS;
                n_last = 1'b0;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = sitod_pkg::ST_DIGITS;
                end
            end
            sitod_pkg::ST_DIGITS: begin
                if (!r_seen && top_digit == 4'd0 && !final_cell) begin
                    // leading zero: drop it
                    cell_op = sitod_pkg::CELL_DIGIT;
                    n_cnt   = r_cnt + 1'b1;
                end else if (out_free) begin
                    out_load = 1'b1;
                    cell_op  = sitod_pkg::CELL_DIGIT;
                    n_cnt    = r_cnt + 1'b1;
                    n_seen   = 1'b1;
                    if (final_cell) begin
                        n_state = sitod_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sitod_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sitod_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_seen <= n_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_char <= n_char;
            r_last <= n_last;
        end
    end

    assign o_stall     = (r_state != sitod_pkg::ST_IDLE);
    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

>>> hdl/sitod_checker.sv
module sitod_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [6:0] o_character,
    input logic       o_last
);

    // held item stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_character) && $stable(o_last))
        else $error("output item changed under stall");

    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_character == sitod_pkg::ASCII_MINUS ||
                    (o_character >= sitod_pkg::ASCII_ZERO &&
                     o_character <= sitod_pkg::ASCII_ZERO + 7'd9))
        else $error("character outside sign and digits");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_character == sitod_pkg::ASCII_MINUS |-> !o_last)
        else $error("minus sign flagged as last");

    // one item at a time: input is blocked right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not blocked after accept");

endmodule

bind signed_int_to_decimal_ascii sitod_checker u_sitod_checker (.*);

>>> dv/signed_int_to_decimal_ascii_tb.sv
module signed_int_to_decimal_ascii_tb;

    localparam int VALUE_WIDTH    = 32;
    localparam logic [VALUE_WIDTH-1:0] RADIX = 10;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 100;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_char_item;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [VALUE_WIDTH-1:0] i_value = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [6:0]                    o_character;
    logic                          o_last;

    logic [VALUE_WIDTH-1:0] pending_values[$];
    t_char_item             expected_text[$];

    int tx_idle_pct  = 19;
    int rx_idle_pct  = 61;
    int hold_trigger = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int error_count  = 0;
    int quiet_cycles = 0;

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Expected text of one integer: optional minus, then digits, MS first.
    function automatic void predict_text(input logic [VALUE_WIDTH-1:0] raw);
        logic                   negative;
        logic [VALUE_WIDTH-1:0] mag;
        logic [3:0]             digits[$];
        t_char_item             entry;
        negative = raw[VALUE_WIDTH-1];
        // magnitude taken unsigned, so the most negative value needs no care
        mag = negative ? (~raw + 1'b1) : raw;
        do begin
            digits.push_front(4'(mag % RADIX));
            mag = mag / RADIX;
        end while (mag != 0);
        if (negative) begin
            entry.ch   = sitod_pkg::ASCII_MINUS;
            entry.last = 1'b0;
            expected_text.push_back(entry);
        end
        foreach (digits[k]) begin
            entry.ch   = sitod_pkg::ASCII_ZERO + 7'(digits[k]);
            entry.last = (k == digits.size() - 1);
            expected_text.push_back(entry);
        end
    endfunction

    // Mostly values of a random digit count, so short and long texts mix evenly
    task automatic queue_random_values(input int count);
        int unsigned ndig;
        int unsigned lo;
        int unsigned hi;
        int unsigned mag;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3) == 0) begin
                pending_values.push_back($urandom);
            end else begin
                ndig = $urandom_range(10, 1);
                lo   = 1;
                repeat (ndig - 1) lo = lo * RADIX;
                hi   = (ndig == 10) ? 32'h7FFF_FFFF : lo * RADIX - 1;
                if (ndig == 1) begin
                    lo = 0;
                end
                mag = $urandom_range(hi, lo);
                pending_values.push_back($urandom_range(1) ? -mag : mag);
            end
        end
    endtask

    task automatic drain();
        while (pending_values.size() != 0 || i_valid || expected_text.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Driver
    always @(posedge i_clk) begin
        logic offering;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_text(pending_values[0]);
                pending_values.pop_front();
                offering = 1'b0;
            end else begin
                offering = i_valid;
            end
            if (!offering && pending_values.size() != 0 &&
                $urandom_range(99) >= tx_idle_pct) begin
                i_value  <= pending_values[0];
                offering = 1'b1;
            end
            i_valid <= offering;
        end
    end

    // Monitor and output stall
    always @(posedge i_clk) begin
        t_char_item want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_text.size() == 0) begin
                    if (error_count < MAX_REPORTS) begin
                        $display("unexpected item: character %0d last %0b",
                                 o_character, o_last);
                    end
                    error_count++;
                end else begin
                    want = expected_text.pop_front();
                    if (o_character !== want.ch || o_last !== want.last) begin
                        if (error_count < MAX_REPORTS) begin
                            $display("mismatch: expected character %0d last %0b, got %0d %0b",
                                     want.ch, want.last, o_character, o_last);
                        end
                        error_count++;
                    end
                end
            end
            if (hold_seen != hold_trigger) begin
                hold_seen = hold_trigger;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Watchdog: only counts while work is outstanding
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (pending_values.size() == 0 && !i_valid && expected_text.size() == 0)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("signed_int_to_decimal_ascii_tb: done, errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero, single digits, powers of ten, both extremes, alternating bits
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(32'd9);
        pending_values.push_back(-32'sd9);
        pending_values.push_back(32'd10);
        pending_values.push_back(-32'sd10);
        pending_values.push_back(32'd99);
        pending_values.push_back(32'd100);
        pending_values.push_back(32'd999999999);
        pending_values.push_back(32'd1000000000);
        pending_values.push_back(-32'sd1000000000);
        pending_values.push_back(32'd123456789);
        pending_values.push_back(-32'sd123456789);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h7FFF_FFFE);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h8000_0001);
        pending_values.push_back(32'h5555_5555);
        pending_values.push_back(32'hAAAA_AAAA);
        pending_values.push_back(32'hFFFF_FFF6);
        drain();

        // long output hold while items keep coming, so the input backs up
        tx_idle_pct = 0;
        hold_trigger++;
        queue_random_values(12);
        drain();

        tx_idle_pct = 19;
        rx_idle_pct = 61;
        queue_random_values(90);
        drain();

        tx_idle_pct = 61;
        rx_idle_pct = 19;
        queue_random_values(100);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random_values(100);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_text.size() != 0) begin
            $display("%0d expected characters never arrived", expected_text.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("signed_int_to_decimal_ascii_tb: done, clean");
        end else begin
            $display("signed_int_to_decimal_ascii_tb: done, errors");
        end
        $finish;
    end

endmodule
